>>> rtl/core/tlbs_pkg.sv
// ----------------------------------------------------------------------------
// tlbs_pkg
// shared types and constants of the text line block splitter
// ----------------------------------------------------------------------------
`default_nettype none

package tlbs_pkg;

  localparam int unsigned MAX_RECS = 3;  // records one byte can cause
  localparam int unsigned CNT_W    = 2;  // holds 0 .. MAX_RECS

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [7:0] LINES_RESET = 8'd8;

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_BREAK = 2'd1,
    KIND_BLOCK = 2'd2
  } tlbs_kind_t;

  // one accepted source byte
  typedef struct packed {
    logic [7:0] byte_value;
    logic       segment_end;
    logic       source_end;
  } tlbs_item_t;

  // one output record, run_last added at the output
  typedef struct packed {
    tlbs_kind_t  kind;
    logic [31:0] start_offset;
    logic [31:0] byte_length;
    logic [7:0]  line_total;
    logic [15:0] record_total;
    logic        continued;
  } tlbs_rec_t;

endpackage

`default_nettype wire

>>> rtl/core/tlbs_tracker.sv
// ----------------------------------------------------------------------------
// tlbs_tracker
// line, run and block state with the per-byte record logic
// ----------------------------------------------------------------------------
`default_nettype none

module tlbs_tracker
  import tlbs_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [7:0]                    lines_per_block,
  input  wire tlbs_item_t                    item,
  input  wire logic                          take,
  output tlbs_rec_t [MAX_RECS-1:0]           recs,
  output logic      [CNT_W-1:0]              rec_count
);

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] run_start;
    logic        in_run;
    logic        cr_waiting;
    logic [31:0] cr_offset;
    logic [7:0]  lines_so_far;
    logic [31:0] block_start;
    logic [15:0] records_so_far;
    logic        seen_block;
  } state_t;

  typedef struct packed {
    state_t    st;
    tlbs_rec_t rec;
  } ending_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // one line ending: a hard break, or the block end that replaces it
  function automatic ending_t line_ending(input state_t s, input logic [7:0] lim,
                                          input logic [31:0] start,
                                          input logic [31:0] len, input logic more);
    ending_t     r;
    logic [31:0] end_pos;
    r       = '0;
    r.st    = s;
    end_pos = start + len;
    r.st.lines_so_far = s.lines_so_far + 8'd1;
    if (r.st.lines_so_far >= lim && more) begin
      r.rec.kind         = KIND_BLOCK;
      r.rec.start_offset = s.block_start;
      r.rec.byte_length  = end_pos - s.block_start;
      r.rec.line_total   = r.st.lines_so_far;
      r.rec.record_total = s.records_so_far;
      r.rec.continued    = s.seen_block;
      r.st.seen_block     = 1'b1;
      r.st.block_start    = end_pos;
      r.st.lines_so_far   = '0;
      r.st.records_so_far = '0;
    end else begin
      r.rec.kind         = KIND_BREAK;
      r.rec.start_offset = start;
      r.rec.byte_length  = len;
      r.st.records_so_far = sat_inc(s.records_so_far);
    end
    return r;
  endfunction

  state_t                    state;
  state_t                    s;
  ending_t                   le_a;
  ending_t                   le_b;
  tlbs_rec_t [MAX_RECS-1:0]  rec;
  logic      [CNT_W-1:0]     n;
  logic      [31:0]          here;
  logic      [7:0]           limit;
  logic                      consumed;
  logic                      is_cr;
  logic                      is_lf;

  assign limit = (lines_per_block == 8'd0) ? 8'd1 : lines_per_block;
  assign is_cr = (item.byte_value == CHAR_CR);
  assign is_lf = (item.byte_value == CHAR_LF);
  assign here  = state.position;

  always_comb begin
    s        = state;
    n        = '0;
    rec      = '0;
    le_a     = '0;
    le_b     = '0;
    consumed = 1'b0;

    // a held cr closes now, as a pair with lf or on its own
    if (s.cr_waiting) begin
      s.cr_waiting = 1'b0;
      if (is_lf) begin
        le_a     = line_ending(s, limit, s.cr_offset, 32'd2, !item.source_end);
        consumed = 1'b1;
      end else begin
        le_a = line_ending(s, limit, s.cr_offset, 32'd1, 1'b1);
      end
      s      = le_a.st;
      rec[n] = le_a.rec;
      n      = n + 1'b1;
    end

    if (!consumed) begin
      if (is_cr || is_lf) begin
        if (s.in_run) begin
          rec[n].kind         = KIND_TEXT;
          rec[n].start_offset = s.run_start;
          rec[n].byte_length  = here - s.run_start;
          n                   = n + 1'b1;
          s.records_so_far    = sat_inc(s.records_so_far);
          s.in_run            = 1'b0;
        end
        if (is_cr && !item.source_end) begin
          s.cr_waiting = 1'b1;
          s.cr_offset  = here;
        end else begin
          le_b   = line_ending(s, limit, here, 32'd1, !item.source_end);
          s      = le_b.st;
          rec[n] = le_b.rec;
          n      = n + 1'b1;
        end
      end else begin
        if (!s.in_run) begin
          s.in_run    = 1'b1;
          s.run_start = here;
        end
        if (item.segment_end || item.source_end) begin
          rec[n].kind         = KIND_TEXT;
          rec[n].start_offset = s.run_start;
          rec[n].byte_length  = here + 32'd1 - s.run_start;
          n                   = n + 1'b1;
          s.records_so_far    = sat_inc(s.records_so_far);
          s.in_run            = 1'b0;
          if (item.source_end) begin
            s.lines_so_far = s.lines_so_far + 8'd1;
          end
        end
      end
    end

    s.position = here + 32'd1;

    // end of source closes the block and starts afresh
    if (item.source_end) begin
      rec[n].kind         = KIND_BLOCK;
      rec[n].start_offset = s.block_start;
      rec[n].byte_length  = s.position - s.block_start;
      rec[n].line_total   = s.lines_so_far;
      rec[n].record_total = s.records_so_far;
      rec[n].continued    = s.seen_block;
      n                   = n + 1'b1;
      s                   = '0;
    end
  end

  assign recs      = rec;
  assign rec_count = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (take) begin
      state <= s;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tlbs_out.sv
// ----------------------------------------------------------------------------
// tlbs_out
// result register of up to three records, handed out one per transaction
// ----------------------------------------------------------------------------
`default_nettype none

module tlbs_out
  import tlbs_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       load,
  input  wire tlbs_rec_t [MAX_RECS-1:0]   recs_in,
  input  wire logic [CNT_W-1:0]           count_in,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output tlbs_rec_t                       out_rec,
  output logic                            out_last,
  output logic                            free
);

  tlbs_rec_t [MAX_RECS-1:0] slots;
  logic      [CNT_W-1:0]    cnt;
  logic      [CNT_W-1:0]    idx;
  logic                     valid;
  logic                     pop;

  assign out_last  = (idx == cnt - 1'b1);
  assign pop       = valid && out_ready;
  assign free      = !valid || (pop && out_last);
  assign out_valid = valid;
  assign out_rec   = slots[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= '0;
      idx   <= '0;
    end else if (load) begin
      valid <= (count_in != '0);
      cnt   <= count_in;
      idx   <= '0;
    end else if (pop) begin
      if (out_last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= recs_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/text_line_block_splitter.sv
// ----------------------------------------------------------------------------
// text_line_block_splitter
// cuts a plain-text byte stream into text runs, hard breaks and line blocks
// ----------------------------------------------------------------------------
// The block takes one source byte per transaction and emits records: a text
// record per run of bytes other than cr and lf (also cut at a segment end), a
// hard-break record per cr, lf or crlf (a crlf may straddle a segment end),
// and a block-end record after lines_per_block line endings when more data
// follows (replacing that break) and at the end of the source. A byte flows
// through an input register, one pass of record logic and a result register
// holding up to three records. Bytes stream at one per cycle while each byte
// yields at most one record and m_axis_tready is high; a byte that yields k
// records holds the result register for k output transactions, stalling the
// input. A cr is held until the next byte, so its break leaves one byte later.
// lines_per_block is to be written through the cfg port while idle; the block
// does not enforce this. Zero acts as one; the source end resets the tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_block_splitter
  import tlbs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,

  // configuration: lines_per_block
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_data,

  // source bytes
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // byte_value
  input  wire logic [0:0]   s_axis_tuser,   // segment_end
  input  wire logic         s_axis_tlast,   // source_end

  // records
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [95:0]       m_axis_tdata,   // start_offset, byte_length, line_total,
                                            // record_total, continued, zero fill
  output logic [1:0]        m_axis_tuser,   // record_kind
  output logic              m_axis_tlast    // run_last
);

  logic [7:0] lines_per_block;
  tlbs_item_t in_item;
  logic       in_valid;
  logic       take;
  logic       slot_free;

  tlbs_rec_t [MAX_RECS-1:0] step_recs;
  logic      [CNT_W-1:0]    step_count;
  tlbs_rec_t                out_rec;

  // configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lines_per_block <= LINES_RESET;
    end else if (cfg_valid) begin
      lines_per_block <= cfg_data;
    end
  end

  // input register: refilled in the same cycle the held byte moves on
  assign take          = in_valid && slot_free;
  assign s_axis_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.byte_value  <= s_axis_tdata;
      in_item.segment_end <= s_axis_tuser[0];
      in_item.source_end  <= s_axis_tlast;
    end
  end

  // per-byte record logic and the running line, run and block state
  tlbs_tracker u_tracker (
    .clk             (clk),
    .rst             (rst),
    .lines_per_block (lines_per_block),
    .item            (in_item),
    .take            (take),
    .recs            (step_recs),
    .rec_count       (step_count)
  );

  // result register, drained one record per output transaction
  tlbs_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .recs_in   (step_recs),
    .count_in  (step_count),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_rec   (out_rec),
    .out_last  (m_axis_tlast),
    .free      (slot_free)
  );

  // pack the record fields, lowest first
  assign m_axis_tuser = out_rec.kind;
  assign m_axis_tdata = {7'd0, out_rec.continued, out_rec.record_total,
                         out_rec.line_total, out_rec.byte_length,
                         out_rec.start_offset};

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the text line block splitter
// ----------------------------------------------------------------------------
// Source bytes go in on the slave stream, with random gaps. Records are taken
// from the master stream under random back-pressure. A behavioural line
// splitter inside the bench tracks offsets, runs, pending cr, line and record
// counts, and queues the records that each accepted byte should cause. Every
// record taken from the block is checked field by field against the oldest
// queued record. Directed tests come first: segment cuts, every line ending,
// byte extremes, source ends and line limits. Random traffic under several
// line limits follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench
  import tlbs_pkg::*;
();

  // one expected record with its end-of-byte flag
  typedef struct packed {
    tlbs_rec_t rec;
    logic      last;
  } split_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // byte_value
  logic [0:0]  s_axis_tuser = '0;    // segment_end
  logic        s_axis_tlast = 1'b0;  // source_end

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;         // start_offset, byte_length, line_total,
                                     // record_total, continued, zero fill
  logic [1:0]  m_axis_tuser;         // record_kind
  logic        m_axis_tlast;         // run_last

  // no random idling on either side while set
  bit          steady = 1'b0;
  int unsigned error_count = 0;
  int unsigned record_index = 0;

  // bench copy of the splitter state
  logic [7:0]  lines_limit = LINES_RESET;
  logic [31:0] byte_pos = '0;
  logic [31:0] run_begin = '0;
  logic        in_text = 1'b0;
  logic        cr_held = 1'b0;
  logic [31:0] cr_pos = '0;
  logic [7:0]  block_lines = '0;
  logic [31:0] block_origin = '0;
  logic [15:0] block_records = '0;
  logic        had_block = 1'b0;

  split_rec_t  byte_records[$];
  split_rec_t  pending_records[$];

  text_line_block_splitter uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // generous bound on the whole run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // line splitter prediction
  // ------------------------------------------------------------------

  function automatic void add_record(tlbs_kind_t kind, logic [31:0] start,
                                     logic [31:0] length, logic [7:0] lines,
                                     logic [15:0] records, logic cont);
    split_rec_t r;
    r.rec.kind         = kind;
    r.rec.start_offset = start;
    r.rec.byte_length  = length;
    r.rec.line_total   = lines;
    r.rec.record_total = records;
    r.rec.continued    = cont;
    r.last             = 1'b0;
    byte_records       = {byte_records, r};
  endfunction

  // record count saturates at its top value
  function automatic void count_in_block();
    if (block_records != 16'hFFFF) block_records = block_records + 16'd1;
  endfunction

  function automatic void close_text(logic [31:0] end_pos);
    add_record(KIND_TEXT, run_begin, end_pos - run_begin, '0, '0, 1'b0);
    count_in_block();
    in_text = 1'b0;
  endfunction

  // a line ending either becomes a break or closes the block in its place
  function automatic void end_line(logic [31:0] start, logic [31:0] length, bit more);
    logic [7:0]  limit;
    logic [31:0] end_pos;
    limit       = (lines_limit == 8'd0) ? 8'd1 : lines_limit;
    end_pos     = start + length;
    block_lines = block_lines + 8'd1;
    if (block_lines >= limit && more) begin
      add_record(KIND_BLOCK, block_origin, end_pos - block_origin, block_lines,
                 block_records, had_block);
      had_block     = 1'b1;
      block_origin  = end_pos;
      block_lines   = '0;
      block_records = '0;
    end else begin
      add_record(KIND_BREAK, start, length, '0, '0, 1'b0);
      count_in_block();
    end
  endfunction

  function automatic void split_byte(logic [7:0] value, logic seg_end, logic src_end);
    logic [31:0] here;
    bit          taken;
    here  = byte_pos;
    taken = 1'b0;
    byte_records.delete();

    // a held cr is resolved by the byte after it
    if (cr_held) begin
      cr_held = 1'b0;
      if (value == CHAR_LF) begin
        end_line(cr_pos, 32'd2, !src_end);
        taken = 1'b1;
      end else begin
        end_line(cr_pos, 32'd1, 1'b1);
      end
    end

    if (!taken) begin
      if (value == CHAR_CR || value == CHAR_LF) begin
        if (in_text) close_text(here);
        if (value == CHAR_CR && !src_end) begin
          cr_held = 1'b1;
          cr_pos  = here;
        end else begin
          end_line(here, 32'd1, !src_end);
        end
      end else begin
        if (!in_text) begin
          in_text   = 1'b1;
          run_begin = here;
        end
        // source end cuts the run too and counts it as a line
        if (seg_end || src_end) begin
          close_text(here + 32'd1);
          if (src_end) block_lines = block_lines + 8'd1;
        end
      end
    end

    byte_pos = here + 32'd1;

    if (src_end) begin
      add_record(KIND_BLOCK, block_origin, byte_pos - block_origin, block_lines,
                 block_records, had_block);
      // a new source starts from offset zero
      byte_pos      = '0;
      run_begin     = '0;
      in_text       = 1'b0;
      cr_held       = 1'b0;
      cr_pos        = '0;
      block_lines   = '0;
      block_origin  = '0;
      block_records = '0;
      had_block     = 1'b0;
    end

    if (byte_records.size() != 0) byte_records[$].last = 1'b1;
    pending_records = {pending_records, byte_records};
  endfunction

  // ------------------------------------------------------------------
  // record checking
  // ------------------------------------------------------------------

  task automatic flag_error(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    error_count++;
    if (error_count <= 40)
      $display("record %0d: %s got %0h expected %0h", record_index, what, got, want);
  endtask

  always @(posedge clk) begin : record_check
    split_rec_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_records.size() == 0) begin
        flag_error("record with none expected, start_offset", m_axis_tdata[31:0], '0);
      end else begin
        want = pending_records.pop_front();
        if (m_axis_tuser !== want.rec.kind)
          flag_error("record_kind", 32'(m_axis_tuser), 32'(want.rec.kind));
        if (m_axis_tdata[31:0] !== want.rec.start_offset)
          flag_error("start_offset", m_axis_tdata[31:0], want.rec.start_offset);
        if (m_axis_tdata[63:32] !== want.rec.byte_length)
          flag_error("byte_length", m_axis_tdata[63:32], want.rec.byte_length);
        if (m_axis_tdata[71:64] !== want.rec.line_total)
          flag_error("line_total", 32'(m_axis_tdata[71:64]), 32'(want.rec.line_total));
        if (m_axis_tdata[87:72] !== want.rec.record_total)
          flag_error("record_total", 32'(m_axis_tdata[87:72]),
                     32'(want.rec.record_total));
        if (m_axis_tdata[88] !== want.rec.continued)
          flag_error("continued", 32'(m_axis_tdata[88]), 32'(want.rec.continued));
        if (m_axis_tdata[95:89] !== '0)
          flag_error("zero fill", 32'(m_axis_tdata[95:89]), '0);
        if (m_axis_tlast !== want.last)
          flag_error("run_last", 32'(m_axis_tlast), 32'(want.last));
      end
      record_index++;
    end
  end

  // receiver back-pressure, about 30 percent of the time
  always @(posedge clk) begin
    m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 30);
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------

  // one source byte transaction, preceded by a random gap
  task automatic send_byte(input logic [7:0] value, input logic seg_end = 1'b0,
                           input logic src_end = 1'b0);
    while (!steady && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= seg_end;
    s_axis_tlast  <= src_end;
    do @(posedge clk); while (!s_axis_tready);
    split_byte(value, seg_end, src_end);
  endtask

  // let every expected record out, then allow for the pipeline depth
  task automatic drain_records();
    s_axis_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only written with the block idle
  task automatic write_lines_per_block(input logic [7:0] value);
    drain_records();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    lines_limit  = value;
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // text run cut at a segment edge, then a line feed
  task automatic test_segment_cuts();
    send_byte("a");
    send_byte("b", 1'b1);
    send_byte(CHAR_LF);
  endtask

  // crlf, lone cr, crlf across a segment edge, cr followed by cr
  task automatic test_line_endings();
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);
    send_byte("x");
    send_byte(CHAR_CR, 1'b1);
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  // lowest and highest byte values and the neighbours of cr
  task automatic test_byte_extremes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h0C);
    send_byte(8'h0E, 1'b1);
  endtask

  // run ending the source, cr as the last byte, crlf ending the source
  task automatic test_source_ends();
    send_byte("q", 1'b0, 1'b1);
    send_byte("r");
    send_byte(CHAR_CR, 1'b0, 1'b1);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF, 1'b0, 1'b1);
  endtask

  // zero limit acting as one, and a lower limit set mid-block
  task automatic test_line_limits();
    write_lines_per_block(8'd0);
    send_byte(CHAR_LF);
    send_byte(CHAR_LF);
    write_lines_per_block(8'd255);
    send_byte(CHAR_LF);
    send_byte(CHAR_LF);
    send_byte(CHAR_LF);
    write_lines_per_block(8'd2);
    send_byte(CHAR_LF);
  endtask

  // mostly text lines with mixed endings, some raw noise and segment cuts
  task automatic test_random_text(input logic [7:0] limit, input int unsigned count,
                                  input bit no_idle, input bit close_source);
    logic [7:0]  value;
    logic        seg_end;
    logic        src_end;
    logic        after_cr;
    int unsigned pick;
    write_lines_per_block(limit);
    steady   = no_idle;
    after_cr = 1'b0;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (after_cr && pick < 50) value = CHAR_LF;
      else if (pick < 12)        value = CHAR_LF;
      else if (pick < 22)        value = CHAR_CR;
      else if (pick < 35)        value = 8'($urandom_range(255));
      else                       value = 8'($urandom_range(126, 32));
      seg_end = ($urandom_range(99) < 12);
      src_end = ($urandom_range(99) < 3) || (close_source && n == count - 1);
      send_byte(value, seg_end, src_end);
      after_cr = (value == CHAR_CR);
    end
    steady = 1'b0;
  endtask

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_segment_cuts();
    test_line_endings();
    test_byte_extremes();
    test_source_ends();
    test_line_limits();

    test_random_text(8'd1, 90, 1'b0, 1'b0);
    test_random_text(8'd255, 90, 1'b1, 1'b0);
    test_random_text(8'd3, 90, 1'b0, 1'b0);
    test_random_text(8'($urandom_range(6, 2)), 80, 1'b0, 1'b1);

    drain_records();
    repeat (10) @(posedge clk);
    if (pending_records.size() != 0)
      flag_error("records never received", 32'(pending_records.size()), '0);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
